FILE: rtl/core/skfk_pkg.sv
package skfk_pkg;

    // Default table depth, one entry per joint of a pose.
    localparam int MAX_JOINTS_DEF = 64;

    localparam int POS_W = 32;
    localparam int ROT_W = 16;

    // Table entry: {bad, pos x, pos y, pos z, rot w, rot x, rot y, rot z}.
    localparam int ENTRY_W = 1 + 3 * POS_W + 4 * ROT_W;

    // Saturate a wide signed sum to the Q16.16 position range.
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/skfk_ram.sv
module skfk_ram #(
    parameter int WIDTH = skfk_pkg::ENTRY_W,
    parameter int DEPTH = skfk_pkg::MAX_JOINTS_DEF
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/skeleton_forward_kinematics_top.sv
// Channel | Handshake          | Payload
// input   | in_valid, in_stall | parent_joint, bone_offset_x/y/z, local_rot_w/x/y/z,
//         |                    | root_pos_x/y/z, pose_end
// output  | out_valid, out_stall | world_pos_x/y/z, world_rot_w/x/y/z, bad_parent,
//         |                    | final_joint
//
// One joint is worked at a time. A child joint passes through one table read,
// 31 steps on the single shared 38x17 multiplier (quaternion product, then the offset
// rotation), a few scaling steps, 8 multiplier steps for the squared norm, a 31-step
// bit-serial square root and a 17-step four-lane divider. A root joint skips the
// quaternion and offset steps; a bad parent goes from the table read to the write-back.
// Reset (rst_n, asynchronous, active low) clears the joint counter and control state;
// the joint table itself is not cleared, since each entry carries its own bad flag and
// only entries written earlier in the same pose are ever used.
// A finished transfer waits in the output register while the next joint is accepted.
module skeleton_forward_kinematics_top #(
    parameter int MAX_JOINTS = skfk_pkg::MAX_JOINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [6:0]  parent_joint,
    input  logic signed [31:0] bone_offset_x,
    input  logic signed [31:0] bone_offset_y,
    input  logic signed [31:0] bone_offset_z,
    input  logic signed [15:0] local_rot_w,
    input  logic signed [15:0] local_rot_x,
    input  logic signed [15:0] local_rot_y,
    input  logic signed [15:0] local_rot_z,
    input  logic signed [31:0] root_pos_x,
    input  logic signed [31:0] root_pos_y,
    input  logic signed [31:0] root_pos_z,
    input  logic               pose_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] world_pos_x,
    output logic signed [31:0] world_pos_y,
    output logic signed [31:0] world_pos_z,
    output logic signed [15:0] world_rot_w,
    output logic signed [15:0] world_rot_x,
    output logic signed [15:0] world_rot_y,
    output logic signed [15:0] world_rot_z,
    output logic               bad_parent,
    output logic               final_joint
);

    localparam int AW = $clog2(MAX_JOINTS);
    localparam int EW = skfk_pkg::ENTRY_W;

    // Sign pattern of the sixteen Hamilton product terms, component-major.
    localparam logic [15:0] QNEG = 16'b0100_0010_1000_1110;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MULQ,
        S_NSHIFT,
        S_MULS,
        S_SQRT,
        S_DIV,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        K_C,
        K_T,
        K_P,
        K_N
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic       neg;
        logic       sh15;
        logic       first;
        logic       store;
        kind_t      kind;
        logic [1:0] sel;
    } tag_t;

    state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [5:0] step_reg, step_next;

    logic signed [6:0]  par_reg, par_next;
    logic signed [31:0] off_reg [0:2];
    logic signed [31:0] off_next [0:2];
    logic signed [31:0] root_reg [0:2];
    logic signed [31:0] root_next [0:2];
    logic signed [15:0] loc_reg [0:3];
    logic signed [15:0] loc_next [0:3];
    logic               pend_reg, pend_next;

    logic signed [31:0] pp_reg [0:2];
    logic signed [31:0] pp_next [0:2];
    logic signed [15:0] p_reg [0:3];
    logic signed [15:0] p_next [0:3];
    logic signed [37:0] t_reg [0:2];
    logic signed [37:0] t_next [0:2];
    logic signed [34:0] c_reg [0:3];
    logic signed [34:0] c_next [0:3];
    logic signed [31:0] pos_reg [0:2];
    logic signed [31:0] pos_next [0:2];
    logic signed [15:0] rot_reg [0:3];
    logic signed [15:0] rot_next [0:3];
    logic               bad_reg, bad_next;

    logic signed [54:0] mul_reg, mul_next;
    tag_t               tag_reg, tag_next;
    logic signed [63:0] acc_reg, acc_next;

    logic [61:0] sq_n_reg, sq_n_next;
    logic [61:0] sq_res_reg, sq_res_next;
    logic [60:0] sq_bit_reg, sq_bit_next;

    logic [32:0] rem_reg [0:3];
    logic [32:0] rem_next [0:3];
    logic [16:0] numlo_reg [0:3];
    logic [16:0] numlo_next [0:3];
    logic [16:0] q_reg [0:3];
    logic [16:0] q_next [0:3];
    logic [32:0] dvs_reg, dvs_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] opos_reg [0:2];
    logic signed [31:0] opos_next [0:2];
    logic signed [15:0] orot_reg [0:3];
    logic signed [15:0] orot_next [0:3];
    logic               obad_reg, obad_next;
    logic               oend_reg, oend_next;

    logic               accept;
    logic               out_free;
    logic               ram_we;
    logic [EW-1:0]      ram_wdata;
    logic [EW-1:0]      ram_rdata;
    logic [AW-1:0]      ram_raddr;

    logic signed [37:0] mul_a;
    logic signed [16:0] mul_b;
    logic [1:0]         qi;
    logic [34:0]        abs_c [0:3];
    logic [34:0]        max_ab;
    logic signed [63:0] term;
    logic signed [63:0] acc_sum;
    logic signed [63:0] rnd_sum;
    logic               is_root;
    logic               is_bad;
    logic [61:0]        sq_try;
    logic [45:0]        nume;
    logic [33:0]        rem_sh;
    logic [16:0]        q_new;
    logic [14:0]        q_clip;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_raddr = AW'(parent_joint[5:0]);
    assign ram_we    = (state_reg == S_FINISH) && out_free;
    assign ram_wdata = {bad_reg, pos_reg[0], pos_reg[1], pos_reg[2],
                        rot_reg[0], rot_reg[1], rot_reg[2], rot_reg[3]};

    skfk_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_JOINTS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(cnt_reg),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Magnitudes and their maximum drive the scaling loop and the norm.
    always_comb
    begin
        max_ab = '0;
        for (int k = 0; k < 4; k++)
        begin
            abs_c[k] = c_reg[k][34] ? 35'(-c_reg[k]) : 35'(c_reg[k]);
            if (abs_c[k] > max_ab)
            begin
                max_ab = abs_c[k];
            end
        end
    end

    // The parent is usable only if it is an earlier joint of this pose with a good result.
    assign is_root = (par_reg == -7'sd1);
    assign is_bad  = !is_root && (par_reg[6] || (7'(par_reg[5:0]) >= 7'(cnt_reg) && AW < 7)
                     || (32'(par_reg[5:0]) >= 32'(cnt_reg)) || ram_rdata[EW-1]);

    assign term    = tag_reg.sh15 ? (64'(mul_reg) <<< 15) : 64'(mul_reg);
    assign acc_sum = (tag_reg.first ? 64'sd0 : acc_reg) + (tag_reg.neg ? -term : term);
    assign rnd_sum = (acc_sum + 64'sd8192) >>> 14;
    assign sq_try  = sq_res_reg + 62'(sq_bit_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        par_next       = par_reg;
        pend_next      = pend_reg;
        bad_next       = bad_reg;
        acc_next       = acc_reg;
        sq_n_next      = sq_n_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        dvs_next       = dvs_reg;
        out_valid_next = out_valid_reg;
        obad_next      = obad_reg;
        oend_next      = oend_reg;
        off_next       = off_reg;
        root_next      = root_reg;
        loc_next       = loc_reg;
        pp_next        = pp_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        c_next         = c_reg;
        pos_next       = pos_reg;
        rot_next       = rot_reg;
        rem_next       = rem_reg;
        numlo_next     = numlo_reg;
        q_next         = q_reg;
        opos_next      = opos_reg;
        orot_next      = orot_reg;
        mul_a          = '0;
        mul_b          = '0;
        tag_next       = '0;
        qi             = step_reg[3:2] ^ step_reg[1:0];
        nume           = '0;
        rem_sh         = '0;
        q_new          = '0;
        q_clip         = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    par_next     = parent_joint;
                    off_next[0]  = bone_offset_x;
                    off_next[1]  = bone_offset_y;
                    off_next[2]  = bone_offset_z;
                    loc_next[0]  = local_rot_w;
                    loc_next[1]  = local_rot_x;
                    loc_next[2]  = local_rot_y;
                    loc_next[3]  = local_rot_z;
                    root_next[0] = root_pos_x;
                    root_next[1] = root_pos_y;
                    root_next[2] = root_pos_z;
                    pend_next    = pose_end;
                    bad_next     = 1'b0;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                if (is_root)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pos_next[i] = skfk_pkg::sat32(64'(root_reg[i]) + 64'(off_reg[i]));
                    end
                    for (int k = 0; k < 4; k++)
                    begin
                        c_next[k] = 35'(loc_reg[k]);
                    end
                    state_next = S_NSHIFT;
                end
                else if (is_bad)
                begin
                    bad_next = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        pos_next[i] = '0;
                    end
                    for (int k = 0; k < 4; k++)
                    begin
                        rot_next[k] = '0;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    pp_next[0] = ram_rdata[159:128];
                    pp_next[1] = ram_rdata[127:96];
                    pp_next[2] = ram_rdata[95:64];
                    p_next[0]  = ram_rdata[63:48];
                    p_next[1]  = ram_rdata[47:32];
                    p_next[2]  = ram_rdata[31:16];
                    p_next[3]  = ram_rdata[15:0];
                    step_next  = '0;
                    state_next = S_MULQ;
                end
            end
            S_MULQ:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg < 6'd16)
                begin
                    mul_a          = 38'(loc_reg[qi]);
                    mul_b          = 17'(p_reg[step_reg[1:0]]);
                    tag_next.valid = 1'b1;
                    tag_next.neg   = QNEG[step_reg[3:0]];
                    tag_next.first = (step_reg[1:0] == 2'd0);
                    tag_next.store = (step_reg[1:0] == 2'd3);
                    tag_next.kind  = K_C;
                    tag_next.sel   = step_reg[3:2];
                end
                else if (step_reg < 6'd31)
                begin
                    tag_next.valid = 1'b1;
                    case (step_reg)
                        6'd16:
                        begin
                            mul_a = 38'(off_reg[2]); mul_b = 17'(p_reg[2]);
                            tag_next.first = 1'b1;
                        end
                        6'd17:
                        begin
                            mul_a = 38'(off_reg[1]); mul_b = 17'(p_reg[3]);
                            tag_next.neg = 1'b1; tag_next.store = 1'b1;
                            tag_next.kind = K_T; tag_next.sel = 2'd0;
                        end
                        6'd18:
                        begin
                            mul_a = 38'(off_reg[0]); mul_b = 17'(p_reg[3]);
                            tag_next.first = 1'b1;
                        end
                        6'd19:
                        begin
                            mul_a = 38'(off_reg[2]); mul_b = 17'(p_reg[1]);
                            tag_next.neg = 1'b1; tag_next.store = 1'b1;
                            tag_next.kind = K_T; tag_next.sel = 2'd1;
                        end
                        6'd20:
                        begin
                            mul_a = 38'(off_reg[1]); mul_b = 17'(p_reg[1]);
                            tag_next.first = 1'b1;
                        end
                        6'd21:
                        begin
                            mul_a = 38'(off_reg[0]); mul_b = 17'(p_reg[2]);
                            tag_next.neg = 1'b1; tag_next.store = 1'b1;
                            tag_next.kind = K_T; tag_next.sel = 2'd2;
                        end
                        6'd22:
                        begin
                            mul_a = t_reg[0]; mul_b = 17'(p_reg[0]);
                            tag_next.first = 1'b1;
                        end
                        6'd23:
                        begin
                            mul_a = t_reg[2]; mul_b = 17'(p_reg[2]);
                        end
                        6'd24:
                        begin
                            mul_a = t_reg[1]; mul_b = 17'(p_reg[3]);
                            tag_next.neg = 1'b1; tag_next.store = 1'b1;
                            tag_next.kind = K_P; tag_next.sel = 2'd0;
                        end
                        6'd25:
                        begin
                            mul_a = t_reg[1]; mul_b = 17'(p_reg[0]);
                            tag_next.first = 1'b1;
                        end
                        6'd26:
                        begin
                            mul_a = t_reg[0]; mul_b = 17'(p_reg[3]);
                        end
                        6'd27:
                        begin
                            mul_a = t_reg[2]; mul_b = 17'(p_reg[1]);
                            tag_next.neg = 1'b1; tag_next.store = 1'b1;
                            tag_next.kind = K_P; tag_next.sel = 2'd1;
                        end
                        6'd28:
                        begin
                            mul_a = t_reg[2]; mul_b = 17'(p_reg[0]);
                            tag_next.first = 1'b1;
                        end
                        6'd29:
                        begin
                            mul_a = t_reg[1]; mul_b = 17'(p_reg[1]);
                        end
                        default:
                        begin
                            mul_a = t_reg[0]; mul_b = 17'(p_reg[2]);
                            tag_next.neg = 1'b1; tag_next.store = 1'b1;
                            tag_next.kind = K_P; tag_next.sel = 2'd2;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_NSHIFT;
                end
            end
            S_NSHIFT:
            begin
                if (max_ab == '0)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        rot_next[k] = '0;
                    end
                    state_next = S_FINISH;
                end
                else if (max_ab[34:30] != '0)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        c_next[k] = c_reg[k] >>> 1;
                    end
                end
                else if (!max_ab[29])
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        c_next[k] = c_reg[k] <<< 1;
                    end
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_MULS;
                end
            end
            S_MULS:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg < 6'd8)
                begin
                    mul_a          = 38'(abs_c[step_reg[2:1]]);
                    mul_b          = step_reg[0] ? 17'(abs_c[step_reg[2:1]][14:0])
                                                 : 17'(abs_c[step_reg[2:1]][29:15]);
                    tag_next.valid = 1'b1;
                    tag_next.sh15  = !step_reg[0];
                    tag_next.first = (step_reg == 6'd0);
                    tag_next.store = (step_reg == 6'd7);
                    tag_next.kind  = K_N;
                end
                else
                begin
                    sq_res_next = '0;
                    sq_bit_next = 61'(1) << 60;
                    state_next  = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_n_reg >= sq_try)
                begin
                    sq_n_next   = sq_n_reg - sq_try;
                    sq_res_next = (sq_res_reg >> 1) + 62'(sq_bit_reg);
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0])
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd0)
                begin
                    dvs_next = {sq_res_reg[31:0], 1'b0};
                    for (int k = 0; k < 4; k++)
                    begin
                        nume          = {abs_c[k][29:0], 15'd0} + 46'(sq_res_reg[31:0]);
                        rem_next[k]   = 33'(nume[45:17]);
                        numlo_next[k] = nume[16:0];
                        q_next[k]     = '0;
                    end
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        rem_sh        = {rem_reg[k], numlo_reg[k][16]};
                        numlo_next[k] = numlo_reg[k] << 1;
                        if (rem_sh >= 34'(dvs_reg))
                        begin
                            rem_next[k] = 33'(rem_sh - 34'(dvs_reg));
                            q_new       = {q_reg[k][15:0], 1'b1};
                        end
                        else
                        begin
                            rem_next[k] = rem_sh[32:0];
                            q_new       = {q_reg[k][15:0], 1'b0};
                        end
                        q_next[k] = q_new;
                        q_clip    = q_new[16:15] != 2'd0 ? 15'h7FFF : q_new[14:0];
                        rot_next[k] = c_reg[k][34] ? -16'(q_clip) : 16'(q_clip);
                    end
                    if (step_reg == 6'd17)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    opos_next      = pos_reg;
                    orot_next      = rot_reg;
                    obad_next      = bad_reg;
                    oend_next      = pend_reg;
                    if (pend_reg || (32'(cnt_reg) == MAX_JOINTS - 1))
                    begin
                        cnt_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Accumulate the registered product of the previous step.
        if (tag_reg.valid)
        begin
            acc_next = acc_sum;
            if (tag_reg.store)
            begin
                case (tag_reg.kind)
                    K_C: c_next[tag_reg.sel] = acc_sum[34:0];
                    K_T: t_next[tag_reg.sel] = 38'((acc_sum + 64'sd4096) >>> 13);
                    K_P: pos_next[tag_reg.sel] = skfk_pkg::sat32(64'(pp_reg[tag_reg.sel])
                                               + 64'(off_reg[tag_reg.sel]) + rnd_sum);
                    K_N: sq_n_next = acc_sum[61:0];
                    default: acc_next = acc_sum;
                endcase
            end
        end
    end

    assign mul_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            tag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            tag_reg       <= tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        par_reg    <= par_next;
        pend_reg   <= pend_next;
        bad_reg    <= bad_next;
        mul_reg    <= mul_next;
        acc_reg    <= acc_next;
        sq_n_reg   <= sq_n_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        dvs_reg    <= dvs_next;
        obad_reg   <= obad_next;
        oend_reg   <= oend_next;
        off_reg    <= off_next;
        root_reg   <= root_next;
        loc_reg    <= loc_next;
        pp_reg     <= pp_next;
        p_reg      <= p_next;
        t_reg      <= t_next;
        c_reg      <= c_next;
        pos_reg    <= pos_next;
        rot_reg    <= rot_next;
        rem_reg    <= rem_next;
        numlo_reg  <= numlo_next;
        q_reg      <= q_next;
        opos_reg   <= opos_next;
        orot_reg   <= orot_next;
    end

    assign out_valid   = out_valid_reg;
    assign world_pos_x = opos_reg[0];
    assign world_pos_y = opos_reg[1];
    assign world_pos_z = opos_reg[2];
    assign world_rot_w = orot_reg[0];
    assign world_rot_x = orot_reg[1];
    assign world_rot_y = orot_reg[2];
    assign world_rot_z = orot_reg[3];
    assign bad_parent  = obad_reg;
    assign final_joint = oend_reg;

    // A rejected joint carries no position or rotation.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_parent) |-> (world_pos_x == 0 && world_pos_y == 0
        && world_pos_z == 0 && world_rot_w == 0 && world_rot_x == 0
        && world_rot_y == 0 && world_rot_z == 0))
        else $error("bad parent result is not zero");

    // The last joint of a pose restarts the joint counter.
    a_pose_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && pend_reg) |=> (cnt_reg == '0))
        else $error("joint counter did not restart after pose end");

    // Multiplier steps are issued only by the two multiply phases.
    a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_MULQ && state_reg != S_MULS) |=> !tag_reg.valid)
        else $error("multiplier step outside a multiply phase");

    // No product may still be in flight when a result is written back.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !tag_reg.valid)
        else $error("write back with a pending product");

endmodule
